@@ rtl/core/bppu_pkg.sv @@
// Shared types, constants and pixel decode for the bitplane page pixel unpacker.
`timescale 1ns / 1ps

package bppu_pkg;

  // Fixed field widths
  localparam int CFG_W  = 12;
  localparam int PIX_W  = 11;
  localparam int BYTE_BITS = 8;
  localparam int CNT_W  = 4;   // pixels per item, 0..8

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd480;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd800;

  // Gray levels
  localparam logic [1:0] GRAY_WHITE = 2'd0;
  localparam logic [1:0] GRAY_DARK  = 2'd1;
  localparam logic [1:0] GRAY_LIGHT = 2'd2;
  localparam logic [1:0] GRAY_BLACK = 2'd3;

  // Per-item summary from the geometry unit
  typedef struct packed {
    logic             in_page;
    logic             last_page;
    logic [CNT_W-1:0] count;
  } item_info_t;

  // Decoded pixel value and marks
  typedef struct packed {
    logic [1:0] gray_value;
    logic       black_mark;
    logic       dark_mark;
    logic       gray_mark;
  } pix_t;

  // Decode the pixel at index k (0 = MSB) of the item bytes
  function automatic pix_t pix_decode(input logic two, input logic [BYTE_BITS-1:0] b1,
                                      input logic [BYTE_BITS-1:0] b2, input logic [2:0] k);
    pix_t       p;
    logic [2:0] sh;
    logic [1:0] v;
    sh = 3'd7 - k;
    if (two) begin
      v = {b1[sh], b2[sh]};
    end else begin
      v = b1[sh] ? GRAY_WHITE : GRAY_BLACK;
    end
    p.gray_value = v;
    p.black_mark = (v != GRAY_WHITE);
    p.dark_mark  = two && (v == GRAY_DARK);
    p.gray_mark  = two && ((v == GRAY_DARK) || (v == GRAY_LIGHT));
    return p;
  endfunction

endpackage

@@ rtl/core/bppu_geom.sv @@
// Page geometry: clamps dimensions, sizes the current item and advances the position counters.
`timescale 1ns / 1ps

module bppu_geom import bppu_pkg::*; #(
  parameter int MAX_DIMENSION = 2048,
  parameter int LINE_W = 11,
  parameter int BYTE_W = 8
) (
  input  logic              two_bit_mode,
  input  logic [CFG_W-1:0]  page_width,
  input  logic [CFG_W-1:0]  page_height,
  input  logic [LINE_W-1:0] line_cnt,
  input  logic [BYTE_W-1:0] byte_cnt,
  output item_info_t        info,
  output logic [LINE_W-1:0] fixed_coord,
  output logic [LINE_W-1:0] line_nxt,
  output logic [BYTE_W-1:0] byte_nxt
);

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int EW    = DIM_W + 1;
  localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [EW-1:0]    along;
  logic [EW-1:0]    lines;
  logic [EW-1:0]    nb;
  logic [EW-1:0]    line_e;
  logic [EW-1:0]    byte_e;
  logic [EW-1:0]    rem;
  logic [EW-1:0]    byte_inc;
  logic [EW-1:0]    line_inc;

  // Clamp a dimension register into 1..MAX_DIMENSION
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (CMP_W'(d) > CMP_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  // Line geometry for the selected layout
  always_comb begin
    w      = clamp_dim(page_width);
    h      = clamp_dim(page_height);
    along  = two_bit_mode ? EW'(h) : EW'(w);
    lines  = two_bit_mode ? EW'(w) : EW'(h);
    nb     = (along + EW'(7)) >> 3;
    line_e = EW'(line_cnt);
    byte_e = EW'(byte_cnt);
  end

  // Size the current item
  always_comb begin
    rem            = along - EW'({byte_cnt, 3'b000});
    info.in_page   = (line_e < lines) && (byte_e < nb);
    info.last_page = info.in_page && (line_e == lines - EW'(1)) && (byte_e == nb - EW'(1));
    if (!info.in_page) begin
      info.count = '0;
    end else if (rem >= EW'(8)) begin
      info.count = CNT_W'(8);
    end else begin
      info.count = CNT_W'(rem);
    end
    fixed_coord = two_bit_mode ? LINE_W'(EW'(w) - line_e - EW'(1)) : line_cnt;
  end

  // Advance and wrap the position counters
  always_comb begin
    byte_inc = byte_e + EW'(1);
    line_inc = line_e;
    if (byte_inc >= nb) begin
      byte_inc = '0;
      line_inc = line_e + EW'(1);
    end
    if (line_inc >= lines) begin
      line_inc = '0;
      byte_inc = '0;
    end
    line_nxt = LINE_W'(line_inc);
    byte_nxt = BYTE_W'(byte_inc);
  end

endmodule

@@ rtl/core/bitplane_page_pixel_unpacker.sv @@
// Top level of the bitplane page pixel unpacker: config registers, item register and pixel output.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | input     | in_valid/in_stall  | first_plane_byte, second_plane_byte
//  out_    | output    | out_valid/out_stall| pixel_x, pixel_y, gray_value, marks, flags
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index (0 mode, 1 width, 2 height), data
//
// One byte item yields 0 to 8 pixel transfers, one per cycle while out_stall is
// low; an item holds the item register until its last pixel passes through the
// single pixel decode path feeding the output register. A full 8-pixel item streams with
// no gap to the next one. Reset clears counters and config to page defaults.
// out_stall holds the output register and, through it, the item register.
`timescale 1ns / 1ps

module bitplane_page_pixel_unpacker import bppu_pkg::*; #(
  parameter int MAX_DIMENSION = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_BITS-1:0] in_first_plane_byte,
  input  logic [BYTE_BITS-1:0] in_second_plane_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel_x,
  output logic [PIX_W-1:0]     out_pixel_y,
  output logic [1:0]           out_gray_value,
  output logic                 out_black_mark,
  output logic                 out_dark_mark,
  output logic                 out_gray_mark,
  output logic                 out_last_of_byte,
  output logic                 out_page_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LINE_W    = $clog2(MAX_DIMENSION);
  localparam int MAX_BYTES = (MAX_DIMENSION + 7) / 8;
  localparam int BYTE_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int POS_W     = BYTE_W + 3;

  // Configuration registers
  logic             mode_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;

  // Position counters
  logic [LINE_W-1:0] line_r;
  logic [BYTE_W-1:0] byte_r;

  // Item register
  logic                 item_vld_r;
  logic                 item_mode_r;
  logic [BYTE_BITS-1:0] b1_r;
  logic [BYTE_BITS-1:0] b2_r;
  logic [LINE_W-1:0]    fix_r;
  logic [BYTE_W-1:0]    base_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [2:0]           k_r;
  logic                 lastpg_r;

  // Output register
  logic             out_valid_r;
  logic [PIX_W-1:0] x_r;
  logic [PIX_W-1:0] y_r;
  pix_t             pix_r;
  logic             last_r;
  logic             done_r;

  item_info_t        info;
  logic [LINE_W-1:0] fixed_coord;
  logic [LINE_W-1:0] line_nxt;
  logic [BYTE_W-1:0] byte_nxt;
  logic              out_adv;
  logic              emit;
  logic              item_last_pix;
  logic              item_done;
  logic              accept;
  logic [POS_W-1:0]  pos;
  pix_t              pix_nxt;

  bppu_geom #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .LINE_W        (LINE_W),
    .BYTE_W        (BYTE_W)
  ) u_geom (
    .two_bit_mode (mode_r),
    .page_width   (width_r),
    .page_height  (height_r),
    .line_cnt     (line_r),
    .byte_cnt     (byte_r),
    .info         (info),
    .fixed_coord  (fixed_coord),
    .line_nxt     (line_nxt),
    .byte_nxt     (byte_nxt)
  );

  // Handshake control
  assign out_adv       = !out_valid_r || !out_stall;
  assign item_last_pix = (CNT_W'(k_r) == cnt_r - CNT_W'(1));
  assign emit          = item_vld_r && (cnt_r != '0) && out_adv;
  assign item_done     = item_vld_r && ((cnt_r == '0) || (out_adv && item_last_pix));
  assign in_stall      = item_vld_r && !item_done;
  assign accept        = in_valid && !in_stall;
  assign cfg_ready     = 1'b1;

  // Decode the current pixel
  assign pos     = {base_r, k_r};
  assign pix_nxt = pix_decode(item_mode_r, b1_r, b2_r, k_r);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Advance position counters on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
      byte_r <= '0;
    end else if (accept) begin
      line_r <= line_nxt;
      byte_r <= byte_nxt;
    end
  end

  // Item register: load on transfer, step through its pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      k_r        <= '0;
    end else if (accept) begin
      item_vld_r <= 1'b1;
      k_r        <= '0;
    end else if (item_done) begin
      item_vld_r <= 1'b0;
    end else if (emit) begin
      k_r <= k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode_r <= mode_r;
      b1_r        <= in_first_plane_byte;
      b2_r        <= in_second_plane_byte;
      fix_r       <= fixed_coord;
      base_r      <= byte_r;
      cnt_r       <= info.count;
      lastpg_r    <= info.last_page;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      x_r    <= item_mode_r ? PIX_W'(fix_r) : PIX_W'(pos);
      y_r    <= item_mode_r ? PIX_W'(pos) : PIX_W'(fix_r);
      pix_r  <= pix_nxt;
      last_r <= item_last_pix;
      done_r <= item_last_pix && lastpg_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = x_r;
  assign out_pixel_y      = y_r;
  assign out_gray_value   = pix_r.gray_value;
  assign out_black_mark   = pix_r.black_mark;
  assign out_dark_mark    = pix_r.dark_mark;
  assign out_gray_mark    = pix_r.gray_mark;
  assign out_last_of_byte = last_r;
  assign out_page_done    = done_r;

  // Pixel index stays inside the item's pixel count
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && (cnt_r != '0)) |-> (CNT_W'(k_r) < cnt_r))
    else $error("pixel index beyond item count");

  // An item never holds more than one byte of pixels
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r |-> (cnt_r <= CNT_W'(8)))
    else $error("item pixel count above eight");

  // End of page only on the last pixel of an item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_done) |-> out_last_of_byte)
    else $error("page end flagged on a non-final pixel");

  // Input stalls only while an item is still emitting
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_vld_r && (cnt_r != '0)))
    else $error("input stalled with no pixels pending");

endmodule
